/* hw/rtl/mpwq_pkg.sv */
`timescale 1ns / 1ps
// mpwq_pkg: shared constants, codes and types of the 3d max pooling query block
// used by mpwq_walker and max_pool_window_query; no dependencies
package mpwq_pkg;

  localparam int MAX_SAMPLES  = 4096;
  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_DIM      = 64;
  localparam int ADDR_BITS    = $clog2(MAX_SAMPLES);
  localparam int DIM_BITS     = 7;
  localparam int POS_BITS     = 6;
  localparam int WIN_BITS     = 4;
  localparam int COORD_BITS   = 10;
  localparam int DIMS_BITS    = 12;
  localparam int CFG_IDX_BITS = 3;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH        = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT       = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH_PLANES = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_DIMS  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE_DIMS  = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] dx;
    logic [DIM_BITS-1:0] dy;
    logic [DIM_BITS-1:0] dz;
    logic [WIN_BITS-1:0] wx;
    logic [WIN_BITS-1:0] wy;
    logic [WIN_BITS-1:0] wz;
    logic [WIN_BITS-1:0] sx;
    logic [WIN_BITS-1:0] sy;
    logic [WIN_BITS-1:0] sz;
  } vol_cfg_t;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic pending;
  } walk_status_t;

endpackage

/* hw/rtl/mpwq_walker.sv */
`timescale 1ns / 1ps
// mpwq_walker: steps through the pooling window one position per cycle and
// turns in-range positions into linear sample memory read requests
// depends on mpwq_pkg
module mpwq_walker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [mpwq_pkg::POS_BITS-1:0] pos_x,
  input  logic [mpwq_pkg::POS_BITS-1:0] pos_y,
  input  logic [mpwq_pkg::POS_BITS-1:0] pos_z,
  input  mpwq_pkg::vol_cfg_t            cfg,
  output mpwq_pkg::rd_req_t             rd_req,
  output mpwq_pkg::walk_status_t        status
);
  import mpwq_pkg::*;

  logic                  walking;
  logic [WIN_BITS-1:0]   fx, fy, fz;
  logic [COORD_BITS-1:0] base_x, base_y, base_z;
  logic                  a_valid;
  logic [COORD_BITS-1:0] a_ix, a_iy, a_iz;
  logic                  b_valid;
  logic [COORD_BITS-1:0] b_ix;
  logic [ADDR_BITS-1:0]  b_t;
  logic                  last_x, last_y, last_z;
  logic                  a_in_range;

  assign last_x = (fx == cfg.wx - WIN_BITS'(1));
  assign last_y = (fy == cfg.wy - WIN_BITS'(1));
  assign last_z = (fz == cfg.wz - WIN_BITS'(1));

  assign a_in_range = (a_ix < COORD_BITS'(cfg.dx)) && (a_iy < COORD_BITS'(cfg.dy)) &&
                      (a_iz < COORD_BITS'(cfg.dz));

  // window counters and control
  always_ff @(posedge clk) begin
    if (rst) begin
      walking <= 1'b0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= walking;
      b_valid <= a_valid && a_in_range;
      if (go) begin
        walking <= (cfg.wx != '0) && (cfg.wy != '0) && (cfg.wz != '0);
      end else if (walking && last_x && last_y && last_z) begin
        walking <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      fx     <= '0;
      fy     <= '0;
      fz     <= '0;
      base_x <= COORD_BITS'(pos_x) * COORD_BITS'(cfg.sx);
      base_y <= COORD_BITS'(pos_y) * COORD_BITS'(cfg.sy);
      base_z <= COORD_BITS'(pos_z) * COORD_BITS'(cfg.sz);
    end else if (walking) begin
      if (last_x) begin
        fx <= '0;
        if (last_y) begin
          fy <= '0;
          fz <= fz + WIN_BITS'(1);
        end else begin
          fy <= fy + WIN_BITS'(1);
        end
      end else begin
        fx <= fx + WIN_BITS'(1);
      end
    end
  end

  // coordinate and address pipeline
  always_ff @(posedge clk) begin
    a_ix <= base_x + COORD_BITS'(fx);
    a_iy <= base_y + COORD_BITS'(fy);
    a_iz <= base_z + COORD_BITS'(fz);
    b_ix <= a_ix;
    b_t  <= ADDR_BITS'(a_iy) + ADDR_BITS'(cfg.dy) * ADDR_BITS'(a_iz);
  end

  assign rd_req.valid   = b_valid;
  assign rd_req.addr    = ADDR_BITS'(b_ix) + ADDR_BITS'(cfg.dx) * b_t;
  assign status.pending = walking || a_valid || b_valid;

endmodule

/* hw/rtl/max_pool_window_query.sv */
`timescale 1ns / 1ps
// max_pool_window_query: sample write and 3d max pooling query over one volume
// a write is taken on the start transfer; a query walks the window through the walker and the
// sample memory read and then strobes done, also when a window size is zero
// throughput: one window position per cycle through the single sample memory read port
// reset clears configuration to defaults and control state; sample memory is not cleared
// results cannot be stalled; depends on mpwq_pkg and mpwq_walker
module max_pool_window_query (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    kind,
  input  logic [mpwq_pkg::ADDR_BITS-1:0]          address,
  input  logic signed [mpwq_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [mpwq_pkg::POS_BITS-1:0]           pos_x,
  input  logic [mpwq_pkg::POS_BITS-1:0]           pos_y,
  input  logic [mpwq_pkg::POS_BITS-1:0]           pos_z,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [mpwq_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [mpwq_pkg::DIMS_BITS-1:0]          cfg_data,
  output logic                                    done,
  output logic signed [mpwq_pkg::SAMPLE_BITS-1:0] max_value,
  output logic                                    window_empty
);
  import mpwq_pkg::*;

  state_t state, state_next;

  logic [DIM_BITS-1:0]  width, height, depth_planes;
  logic [DIMS_BITS-1:0] window_dims, stride_dims;
  vol_cfg_t             vcfg;

  logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic                          rd_valid;

  logic signed [SAMPLE_BITS-1:0] best;
  logic                          found;

  logic         accept, query_accept, write_accept, finish;
  rd_req_t      rd_req;
  walk_status_t walk_status;

  assign cfg_ready    = 1'b1;
  assign accept       = start && !busy;
  assign query_accept = accept && (kind == KIND_QUERY);
  assign write_accept = accept && (kind == KIND_WRITE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width        <= DIM_BITS'(64);
      height       <= DIM_BITS'(64);
      depth_planes <= DIM_BITS'(1);
      window_dims  <= DIMS_BITS'(12'h122);
      stride_dims  <= DIMS_BITS'(12'h122);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH:        width        <= cfg_data[DIM_BITS-1:0];
        REG_HEIGHT:       height       <= cfg_data[DIM_BITS-1:0];
        REG_DEPTH_PLANES: depth_planes <= cfg_data[DIM_BITS-1:0];
        REG_WINDOW_DIMS:  window_dims  <= cfg_data;
        REG_STRIDE_DIMS:  stride_dims  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    vcfg.dx = (width > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : width;
    vcfg.dy = (height > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : height;
    vcfg.dz = (depth_planes > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : depth_planes;
    vcfg.wx = window_dims[3:0];
    vcfg.wy = window_dims[7:4];
    vcfg.wz = window_dims[11:8];
    vcfg.sx = stride_dims[3:0];
    vcfg.sy = stride_dims[7:4];
    vcfg.sz = stride_dims[11:8];
  end

  mpwq_walker u_walker (
    .clk    (clk),
    .rst    (rst),
    .go     (query_accept),
    .pos_x  (pos_x),
    .pos_y  (pos_y),
    .pos_z  (pos_z),
    .cfg    (vcfg),
    .rd_req (rd_req),
    .status (walk_status)
  );

  // sample memory; busy keeps writes and query reads apart
  always_ff @(posedge clk) begin
    if (write_accept) begin
      mem[address] <= sample;
    end
    if (rd_req.valid) begin
      rd_data <= mem[rd_req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_req.valid;
    end
  end

  // running maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (query_accept) begin
      found <= 1'b0;
    end else if (rd_valid) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (query_accept) begin
      best <= SAMPLE_MIN;
    end else if (rd_valid && (!found || (rd_data > best))) begin
      best <= rd_data;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (query_accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!walk_status.pending && !rd_valid) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state == ST_SCAN);
    finish = (state == ST_SCAN) && !walk_status.pending && !rd_valid;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      max_value    <= best;
      window_empty <= !found;
    end
  end

`ifndef SYNTHESIS
  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_IDLE))
    else $error("result strobe outside idle");

  a_reads_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (state == ST_SCAN))
    else $error("sample read outside a query");

  a_query_enters_scan: assert property (@(posedge clk) disable iff (rst)
    query_accept |=> (state == ST_SCAN))
    else $error("query transfer did not start a scan");

  a_no_read_on_write: assert property (@(posedge clk) disable iff (rst)
    write_accept |-> !walk_status.pending && !rd_valid)
    else $error("sample write overlaps a window read");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench of max_pool_window_query, sample writes and window max queries
// a small scoreboard class predicts every query result; depends on mpwq_pkg and the block only
module testbench;
  import mpwq_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  typedef int addr_list_t[$];

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          empty;
  } pool_result_t;

  class pool_board;
    logic [DIM_BITS-1:0]           vol_w = 7'd64;
    logic [DIM_BITS-1:0]           vol_h = 7'd64;
    logic [DIM_BITS-1:0]           vol_d = 7'd1;
    logic [DIMS_BITS-1:0]          win = 12'h122;
    logic [DIMS_BITS-1:0]          strd = 12'h122;
    logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
    bit                            written [MAX_SAMPLES];
    pool_result_t                  maxima[$];
    int                            mismatches = 0;

    function int extent(logic [DIM_BITS-1:0] d);
      return (d > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    function void note_config(logic [CFG_IDX_BITS-1:0] idx, logic [DIMS_BITS-1:0] d);
      case (idx)
        REG_WIDTH:        vol_w = d[DIM_BITS-1:0];
        REG_HEIGHT:       vol_h = d[DIM_BITS-1:0];
        REG_DEPTH_PLANES: vol_d = d[DIM_BITS-1:0];
        REG_WINDOW_DIMS:  win = d;
        REG_STRIDE_DIMS:  strd = d;
        default: ;
      endcase
    endfunction

    function addr_list_t window_addresses(int px, int py, int pz);
      addr_list_t list;
      int dx, dy, dz, ix, iy, iz, fx, fy, fz;
      dx = extent(vol_w);
      dy = extent(vol_h);
      dz = extent(vol_d);
      for (fz = 0; fz < int'(win[11:8]); fz++) begin
        iz = pz * int'(strd[11:8]) + fz;
        if (iz >= dz) continue;
        for (fy = 0; fy < int'(win[7:4]); fy++) begin
          iy = py * int'(strd[7:4]) + fy;
          if (iy >= dy) continue;
          for (fx = 0; fx < int'(win[3:0]); fx++) begin
            ix = px * int'(strd[3:0]) + fx;
            if (ix >= dx) continue;
            list.push_back((ix + dx * (iy + dy * iz)) % MAX_SAMPLES);
          end
        end
      end
      return list;
    endfunction

    function void note_item(logic k, logic [ADDR_BITS-1:0] a, logic signed [SAMPLE_BITS-1:0] s,
                            logic [POS_BITS-1:0] x, logic [POS_BITS-1:0] y,
                            logic [POS_BITS-1:0] z);
      addr_list_t   reads;
      pool_result_t r;
      if (k == KIND_WRITE) begin
        mem[a] = s;
        written[a] = 1'b1;
        return;
      end
      reads = window_addresses(int'(x), int'(y), int'(z));
      r.value = SAMPLE_MIN;
      r.empty = 1'b1;
      foreach (reads[i]) begin
        if (r.empty || mem[reads[i]] > r.value) begin
          r.value = mem[reads[i]];
        end
        r.empty = 1'b0;
      end
      maxima.push_back(r);
    endfunction

    function void check_result(logic signed [SAMPLE_BITS-1:0] v, logic e);
      pool_result_t r;
      if (maxima.size() == 0) begin
        $error("max_value: expected no result, actual %0d", v);
        mismatches++;
        return;
      end
      r = maxima.pop_front();
      if (v !== r.value) begin
        $error("max_value: expected %0d, actual %0d", r.value, v);
        mismatches++;
      end
      if (e !== r.empty) begin
        $error("window_empty: expected %0b, actual %0b", r.empty, e);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic                          kind;
  logic [ADDR_BITS-1:0]          address;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [POS_BITS-1:0]           pos_x;
  logic [POS_BITS-1:0]           pos_y;
  logic [POS_BITS-1:0]           pos_z;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_IDX_BITS-1:0]       cfg_index;
  logic [DIMS_BITS-1:0]          cfg_data;
  logic                          done;
  logic signed [SAMPLE_BITS-1:0] max_value;
  logic                          window_empty;

  pool_board board = new();
  int        items_sent = 0;
  bit        steady = 1'b0;

  max_pool_window_query dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .address(address),
    .sample(sample), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .max_value(max_value), .window_empty(window_empty)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) begin
      board.check_result(max_value, window_empty);
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(0, 39))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return -16'sd1;
      3: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [DIMS_BITS-1:0] random_extent();
    int                  r;
    logic [DIM_BITS-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 70) v = 7'($urandom_range(1, 12));
    else if (r < 85) v = 7'($urandom_range(13, 64));
    else if (r < 93) v = 7'($urandom_range(65, 127));
    else v = '0;
    return {5'($urandom), v};
  endfunction

  function automatic logic [DIMS_BITS-1:0] random_triple(int hi);
    logic [DIMS_BITS-1:0] t;
    int                   r;
    for (int i = 0; i < 3; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) t[i*4 +: 4] = '0;
      else if (r < 88) t[i*4 +: 4] = 4'($urandom_range(1, hi));
      else t[i*4 +: 4] = 4'($urandom_range(1, 15));
    end
    return t;
  endfunction

  // pick a position whose window mostly overlaps the volume
  function automatic logic [POS_BITS-1:0] aim(int extent_sz, logic [3:0] step);
    int reach;
    if (extent_sz == 0 || step == 0) return 6'($urandom_range(0, 63));
    reach = (extent_sz - 1) / int'(step) + 1;
    if (reach > 63) reach = 63;
    return 6'($urandom_range(0, reach));
  endfunction

  task automatic idle_gap();
    int r, n;
    r = $urandom_range(0, 99);
    if (steady || r < 55) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_item(logic k, logic [ADDR_BITS-1:0] a, logic signed [SAMPLE_BITS-1:0] s,
                           logic [POS_BITS-1:0] x, logic [POS_BITS-1:0] y,
                           logic [POS_BITS-1:0] z);
    start <= 1'b1;
    kind <= k;
    address <= a;
    sample <= s;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    do @(posedge clk); while (busy);
    board.note_item(k, a, s, x, y, z);
    items_sent++;
    idle_gap();
  endtask

  task automatic store(logic [ADDR_BITS-1:0] a, logic signed [SAMPLE_BITS-1:0] s);
    send_item(KIND_WRITE, a, s, 6'($urandom), 6'($urandom), 6'($urandom));
  endtask

  // every entry the window reads gets written first
  task automatic run_query(logic [POS_BITS-1:0] x, logic [POS_BITS-1:0] y,
                           logic [POS_BITS-1:0] z);
    addr_list_t reads;
    reads = board.window_addresses(int'(x), int'(y), int'(z));
    foreach (reads[i]) begin
      if (!board.written[reads[i]]) store(12'(reads[i]), random_sample());
    end
    send_item(KIND_QUERY, 12'($urandom), 16'($urandom), x, y, z);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (board.maxima.size() != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [DIMS_BITS-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    board.note_config(idx, d);
  endtask

  task automatic configure(logic [DIMS_BITS-1:0] w, logic [DIMS_BITS-1:0] h,
                           logic [DIMS_BITS-1:0] d, logic [DIMS_BITS-1:0] win,
                           logic [DIMS_BITS-1:0] strd);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_DEPTH_PLANES, d);
    write_reg(REG_WINDOW_DIMS, win);
    write_reg(REG_STRIDE_DIMS, strd);
    write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 12'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int quota);
    int first, r;
    first = items_sent;
    while (items_sent - first < quota) begin
      if ((items_sent - first) % 25 == 0) steady = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 55) begin
        run_query(aim(board.extent(board.vol_w), board.strd[3:0]),
                  aim(board.extent(board.vol_h), board.strd[7:4]),
                  aim(board.extent(board.vol_d), board.strd[11:8]));
      end else if (r < 85) begin
        store(12'($urandom), random_sample());
      end else begin
        run_query(6'($urandom), 6'($urandom), 6'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    kind <= KIND_WRITE;
    address <= '0;
    sample <= '0;
    pos_x <= '0;
    pos_y <= '0;
    pos_z <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 64 x 64 x 1 volume, 2 x 2 x 1 window and stride
    store(12'd0, 16'sh7fff);
    store(12'd1, 16'sh8000);
    store(12'd64, 16'sd0);
    store(12'd65, -16'sd1);
    run_query(6'd0, 6'd0, 6'd0);
    store(12'd4095, -16'sd2);
    run_query(6'd31, 6'd31, 6'd0);
    run_query(6'd63, 6'd63, 6'd63);
    run_query(6'd63, 6'd0, 6'd0);
    run_query(6'd0, 6'd63, 6'd0);
    run_query(6'd0, 6'd0, 6'd63);
    // window holding only the most negative value, not empty
    store(12'd128, 16'sh8000);
    store(12'd129, 16'sh8000);
    store(12'd192, 16'sh8000);
    store(12'd193, 16'sh8000);
    run_query(6'd0, 6'd1, 6'd0);
    store(12'd3, 16'sd5);
    store(12'd66, -16'sd7);
    store(12'd67, 16'sd122);
    send_item(KIND_WRITE, 12'd2, 16'sd123, 6'd63, 6'd63, 6'd63);
    send_item(KIND_QUERY, 12'hfff, 16'sh7fff, 6'd1, 6'd0, 6'd0);

    configure(12'hfff, 12'd3, 12'd2, 12'hfff, 12'hfff);
    random_phase(40);
    configure(12'd1, 12'd1, 12'd1, 12'h111, 12'h111);
    random_phase(40);
    configure(12'd64, 12'd64, 12'd64, 12'h222, 12'h000);
    random_phase(40);
    configure(12'd0, 12'd5, 12'd5, 12'h333, 12'h111);
    random_phase(30);
    configure(12'd8, 12'd8, 12'd8, 12'h303, 12'h212);
    random_phase(30);
    configure(12'd6, 12'd6, 12'd0, 12'h022, 12'h123);
    random_phase(30);
    for (int p = 0; p < 9; p++) begin
      configure(random_extent(), random_extent(), random_extent(),
                random_triple(3), random_triple(4));
      random_phase(120);
    end
    drain();

    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
